// ===== design/cmrr_pkg.sv =====
// Shared constants, types and helpers for the cost matrix row/column reduce block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cmrr_pkg;

   // Matrix geometry
   localparam int MAX_DIM = 16;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DIM_W   = 5;
   localparam int VAL_W   = 11;
   localparam int KIND_W  = 2;

   // Request / acknowledge codes
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // Stored marker for an absent edge (-1)
   localparam logic [VAL_W-1:0] ABSENT = {VAL_W{1'b1}};

   // One memory access slot: one write and one read address per cycle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_port_type;

   // Sequencer status towards the top level
   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

   // Strictly positive cost (not absent, not zero)
   function automatic logic is_positive(input logic [VAL_W-1:0] v);
      is_positive = !v[VAL_W-1] && (v != '0);
   endfunction

   // Address of element k of a line: row pass walks columns, column pass walks rows
   function automatic logic [ADDR_W-1:0] line_addr(input logic col_pass,
                                                    input logic [IDX_W-1:0] line,
                                                    input logic [IDX_W-1:0] k);
      line_addr = col_pass ? {k, line} : {line, k};
   endfunction

endpackage

`default_nettype wire

// ===== design/cmrr_chan_if.sv =====
// Handshake channel interfaces: request, response and the matrix_size register write.
// Depends on cmrr_pkg for field widths.
`default_nettype none

interface cmrr_req_if;
   import cmrr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       req_type;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [VAL_W-1:0] entry_value;

   modport source(output valid, req_type, row_index, col_index, entry_value, input ready);
   modport sink(input valid, req_type, row_index, col_index, entry_value, output ready);
endinterface

interface cmrr_rsp_if;
   import cmrr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       ack_kind;
   logic signed [VAL_W-1:0] read_value;

   modport source(output valid, ack_kind, read_value, input ready);
   modport sink(input valid, ack_kind, read_value, output ready);
endinterface

interface cmrr_csr_if;
   import cmrr_pkg::*;
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] matrix_size;

   modport source(output valid, matrix_size, input ready);
   modport sink(input valid, matrix_size, output ready);
endinterface

`default_nettype wire

// ===== design/cmrr_store.sv =====
// Cost matrix store: single-port-write, single-port-read synchronous memory,
// read data registered. Depends on cmrr_pkg.
`default_nettype none

module cmrr_store (
   input  wire                          clock,
   input  cmrr_pkg::mem_port_type       port,
   output logic [cmrr_pkg::VAL_W-1:0]   rd_data
);
   import cmrr_pkg::*;

   logic [VAL_W-1:0] cost_mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   // Write and read in the same cycle; contents are not reset
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         cost_mem[port.wr_addr] <= port.wr_data;
      end
      rd_data_ff <= cost_mem[port.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/cmrr_seq.sv =====
// Reduction sequencer: row pass then column pass, each line scanned for its
// least positive entry and, if it holds no zero but a positive entry, then read-modify-written. Depends on cmrr_pkg.
`default_nettype none

module cmrr_seq (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [cmrr_pkg::DIM_W-1:0]    dim,
   input  wire [cmrr_pkg::VAL_W-1:0]    rd_data,
   output cmrr_pkg::mem_port_type       port,
   output cmrr_pkg::seq_stat_type       stat
);
   import cmrr_pkg::*;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_SCAN,
      SQ_SUB,
      SQ_DONE
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic              pass_ff, pass_in;       // 0 row pass, 1 column pass
   logic [IDX_W-1:0]  line_ff, line_in;
   logic [DIM_W-1:0]  k_ff, k_in;             // issue counter, reaches dim
   logic              pend_ff, pend_in;       // read issued last cycle
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [VAL_W-2:0]  min_ff, min_in;
   logic              have_ff, have_in;
   logic              zero_ff, zero_in;

   logic              issue;
   logic              last_line;
   logic [VAL_W-1:0]  min_ext;

   assign issue     = (k_ff < dim);
   assign last_line = ({1'b0, line_ff} == (dim - DIM_W'(1)));
   assign min_ext   = {1'b0, min_ff};

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      line_in      = line_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      min_in       = min_ff;
      have_in      = have_ff;
      zero_in      = zero_ff;

      port.wr_en   = 1'b0;
      port.wr_addr = pend_addr_ff;
      port.wr_data = rd_data - min_ext;
      port.rd_addr = line_addr(pass_ff, line_ff, k_ff[IDX_W-1:0]);

      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               pass_in = 1'b0;
               line_in = '0;
               k_in    = '0;
               have_in = 1'b0;
               zero_in = 1'b0;
               state_in = (dim == '0) ? SQ_DONE : SQ_SCAN;
            end
         end
         SQ_SCAN: begin
            // look for a zero and the least positive entry
            pend_in = issue;
            if (issue) begin
               k_in = k_ff + DIM_W'(1);
            end
            if (pend_ff) begin
               if (rd_data == '0) begin
                  zero_in = 1'b1;
               end else if (is_positive(rd_data) &&
                            (!have_ff || (rd_data[VAL_W-2:0] < min_ff))) begin
                  min_in  = rd_data[VAL_W-2:0];
                  have_in = 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               k_in = '0;
               if (zero_ff || !have_ff) begin
                  have_in = 1'b0;
                  zero_in = 1'b0;
                  if (last_line) begin
                     line_in  = '0;
                     pass_in  = 1'b1;
                     state_in = pass_ff ? SQ_DONE : SQ_SCAN;
                  end else begin
                     line_in = line_ff + IDX_W'(1);
                  end
               end else begin
                  state_in = SQ_SUB;
               end
            end
         end
         SQ_SUB: begin
            // read entry k, write it back reduced in the following cycle if it is positive
            pend_in      = issue;
            pend_addr_in = port.rd_addr;
            if (issue) begin
               k_in = k_ff + DIM_W'(1);
            end
            port.wr_en = pend_ff && is_positive(rd_data);
            if (!issue && !pend_ff) begin
               k_in    = '0;
               have_in = 1'b0;
               zero_in = 1'b0;
               if (last_line) begin
                  line_in  = '0;
                  pass_in  = 1'b1;
                  state_in = pass_ff ? SQ_DONE : SQ_SCAN;
               end else begin
                  line_in  = line_ff + IDX_W'(1);
                  state_in = SQ_SCAN;
               end
            end
         end
         SQ_DONE: begin
            state_in = SQ_IDLE;
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         pend_ff  <= 1'b0;
         k_ff     <= '0;
         pass_ff  <= 1'b0;
         line_ff  <= '0;
         have_ff  <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         k_ff     <= k_in;
         pass_ff  <= pass_in;
         line_ff  <= line_in;
         have_ff  <= have_in;
         zero_ff  <= zero_in;
      end
      pend_addr_ff <= pend_addr_in;
      min_ff       <= min_in;
   end

   assign stat.busy = (state_ff != SQ_IDLE);
   assign stat.done = (state_ff == SQ_DONE);

endmodule

`default_nettype wire

// ===== design/cost_matrix_row_column_reduce.sv =====
// Cost matrix row/column reduce, top level. A write answers through the response
// register; a read passes the store's read register, then the response register.
// A reduce scans the n lines in use in the row pass, then in the column pass, through
// the single read port of the store, and at most 2n-1 lines need the subtract. One
// transaction in flight; the next is taken as its response leaves.
// Reset: synchronous, sets matrix_size to 16 and clears control; the store keeps
// its contents and is undefined until written.
`default_nettype none

module cost_matrix_row_column_reduce (
   input  wire       clock,
   input  wire       reset,
   cmrr_req_if.sink  req_if,
   cmrr_rsp_if.source rsp_if,
   cmrr_csr_if.sink  csr_if
);
   import cmrr_pkg::*;

   typedef enum logic [1:0] {
      T_IDLE,
      T_READ,
      T_REDUCE
   } top_state_type;

   top_state_type     state_ff, state_in;
   logic [DIM_W-1:0]  size_ff, size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;

   logic              req_accept;
   logic              seq_start;
   logic [DIM_W-1:0]  dim;
   logic [VAL_W-1:0]  rd_data;
   logic [VAL_W-1:0]  wr_value;
   mem_port_type      seq_port;
   mem_port_type      mem_port;
   seq_stat_type      seq_stat;

   // Request handshake: idle and response slot free or leaving
   assign req_if.ready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;
   assign seq_start    = req_accept && (req_if.req_type == KIND_REDUCE);
   assign csr_if.ready = 1'b1;

   // Rows in use, clipped to the store
   assign dim = (size_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : size_ff;

   // Non-positive costs are kept as absent
   assign wr_value = is_positive(req_if.entry_value) ? req_if.entry_value : ABSENT;

   // Store access: sequencer while reducing, else the request path
   always_comb begin
      if (seq_stat.busy) begin
         mem_port = seq_port;
      end else begin
         mem_port.wr_en   = req_accept && (req_if.req_type == KIND_WRITE);
         mem_port.wr_addr = {req_if.row_index, req_if.col_index};
         mem_port.wr_data = wr_value;
         mem_port.rd_addr = {req_if.row_index, req_if.col_index};
      end
   end

   cmrr_store u_store (
      .clock   (clock),
      .port    (mem_port),
      .rd_data (rd_data)
   );

   cmrr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .dim     (dim),
      .rd_data (rd_data),
      .port    (seq_port),
      .stat    (seq_stat)
   );

   // Transaction control and response register
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;

      if (csr_if.valid) begin
         size_in = csr_if.matrix_size;
      end

      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               case (req_if.req_type)
                  KIND_READ: begin
                     state_in = T_READ;
                  end
                  KIND_REDUCE: begin
                     state_in = T_REDUCE;
                  end
                  default: begin
                     // write or unknown code: answer at once
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = req_if.req_type;
                     rsp_value_in = '0;
                  end
               endcase
            end
         end
         T_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_READ;
            rsp_value_in = rd_data;
            state_in     = T_IDLE;
         end
         T_REDUCE: begin
            if (seq_stat.done) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_REDUCE;
               rsp_value_in = '0;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         size_ff      <= DIM_W'(MAX_DIM);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ack_kind   = rsp_kind_ff;
   assign rsp_if.read_value = rsp_value_ff;

`ifndef SYNTHESIS
   // A read answers the cycle after its data returns
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_READ) |=> (rsp_valid_ff && (rsp_kind_ff == KIND_READ)))
      else $error("read response not loaded");

   // The sequencer only owns the store inside a reduce transaction
   a_seq_owner: assert property (@(posedge clock) disable iff (reset)
      seq_stat.busy |-> (state_ff == T_REDUCE))
      else $error("sequencer active outside reduce");

   // A write transaction answers on the next cycle
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.req_type == KIND_WRITE))
         |=> (rsp_valid_ff && (rsp_kind_ff == KIND_WRITE)))
      else $error("write response not loaded");
`endif

endmodule

`default_nettype wire
